// ----- rtl/tsd_pkg.sv -----
package tsd_pkg;

    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W = CMD_PTR_W + 1;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_VALUE  = 2'd1,
        PH_DROP   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_HDR_INCOMPLETE = 2'd1,
        ST_TOO_LARGE      = 2'd2,
        ST_LEN_EXCEEDS    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_last;
    } t_in;

    typedef struct packed {
        logic [15:0] record_type;
        logic [7:0]  value_byte;
        logic        value_empty;
        logic        value_last;
        logic        body_done;
        t_status     parse_status;
    } t_out;

    // one entry per accepted byte that produces anything: a value/empty result,
    // a body-done result, or both (value first)
    typedef struct packed {
        logic        has_val;
        logic [15:0] record_type;
        logic [7:0]  value_byte;
        logic        value_empty;
        logic        value_last;
        logic        has_done;
        t_status     status;
    } t_cmd;

endpackage

// ----- rtl/tlv_stream_deframer.sv -----
// Path: an accepted byte's result is written into the command queue, then loaded into the output register.
// Throughput: one byte per cycle while the command queue is not full; a byte that yields both a value and a body-done
// result takes two output beats, the 4-entry command queue absorbs the burst.
// full rises only when that queue is full.
// Reset (i_rst_n low, synchronous): queues empty, parser in header phase,
// max_value_length back to 1048576.
module tlv_stream_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  tsd_pkg::t_in  i_item,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output tsd_pkg::t_out o_res,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_not_empty;
    tsd_pkg::t_cmd q_wr_cmd;
    tsd_pkg::t_cmd q_rd_cmd;

    assign full = q_full;

    tsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_wr_cmd)
    );

    tsd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (q_push),
        .i_wr_data   (q_wr_cmd),
        .o_full      (q_full),
        .i_rd_en     (q_pop),
        .o_rd_data   (q_rd_cmd),
        .o_not_empty (q_not_empty)
    );

    tsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_cmd       (q_rd_cmd),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_res         (o_res)
    );

endmodule

// ----- rtl/tsd_front.sv -----
module tsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsd_pkg::t_in  i_item,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_q_full,
    output logic          o_q_push,
    output tsd_pkg::t_cmd o_q_cmd
);

    tsd_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_hdr_cnt, n_hdr_cnt;
    logic [15:0]      r_type, n_type;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_rem, n_rem;
    tsd_pkg::t_status r_err, n_err;
    logic [31:0]      r_max_len;

    logic             accept;
    logic             last;
    logic [7:0]       b;
    logic [31:0]      len_shift;
    logic [31:0]      rem_dec;
    logic             len_big;
    logic             len_zero;
    logic             hdr_done;
    tsd_pkg::t_status err_upd;
    tsd_pkg::t_cmd    cmd;

    assign accept    = i_push & ~i_q_full;
    assign last      = i_item.body_last;
    assign b         = i_item.data_byte;
    assign len_shift = {r_len[23:0], b};
    assign rem_dec   = r_rem - 32'd1;
    assign len_big   = len_shift > r_max_len;
    assign len_zero  = (len_shift == 32'd0);
    assign hdr_done  = (r_hdr_cnt >= 3'd5);

    // datapath and command decode
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_type    = r_type;
        n_len     = r_len;
        n_rem     = r_rem;
        err_upd   = r_err;
        cmd       = '0;
        unique case (r_phase)
            tsd_pkg::PH_DROP: begin
            end
            tsd_pkg::PH_VALUE: begin
                cmd.has_val     = 1'b1;
                cmd.record_type = r_type;
                cmd.value_byte  = b;
                cmd.value_last  = (r_rem == 32'd1);
                n_rem           = rem_dec;
                if ((rem_dec != 32'd0) && last) begin
                    err_upd = tsd_pkg::ST_LEN_EXCEEDS;
                end
            end
            default: begin
                if (r_hdr_cnt < 3'd2) begin
                    n_type = {r_type[7:0], b};
                end else begin
                    n_len = len_shift;
                end
                if (hdr_done) begin
                    n_hdr_cnt = 3'd0;
                    n_len     = 32'd0;
                    if (len_big) begin
                        err_upd = tsd_pkg::ST_TOO_LARGE;
                    end else if (len_zero) begin
                        cmd.has_val     = 1'b1;
                        cmd.record_type = r_type;
                        cmd.value_empty = 1'b1;
                        cmd.value_last  = 1'b1;
                    end else if (last) begin
                        err_upd = tsd_pkg::ST_LEN_EXCEEDS;
                    end else begin
                        n_rem = len_shift;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                    if (last) begin
                        err_upd = tsd_pkg::ST_HDR_INCOMPLETE;
                    end
                end
            end
        endcase
        n_err = err_upd;
        if (last) begin
            cmd.has_done = 1'b1;
            cmd.status   = err_upd;
            n_hdr_cnt    = 3'd0;
            n_type       = 16'd0;
            n_len        = 32'd0;
            n_rem        = 32'd0;
            n_err        = tsd_pkg::ST_OK;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            tsd_pkg::PH_DROP: begin
            end
            tsd_pkg::PH_VALUE: begin
                if (rem_dec == 32'd0) begin
                    n_phase = tsd_pkg::PH_HEADER;
                end
            end
            default: begin
                n_phase = tsd_pkg::PH_HEADER;
                if (hdr_done && !len_big && !len_zero && !last) begin
                    n_phase = tsd_pkg::PH_VALUE;
                end
            end
        endcase
        if ((err_upd != tsd_pkg::ST_OK) && !last) begin
            n_phase = tsd_pkg::PH_DROP;
        end
        if (last) begin
            n_phase = tsd_pkg::PH_HEADER;
        end
    end

    assign o_q_push = accept & (cmd.has_val | cmd.has_done);
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tsd_pkg::PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_type    <= 16'd0;
            r_len     <= 32'd0;
            r_rem     <= 32'd0;
            r_err     <= tsd_pkg::ST_OK;
            r_max_len <= tsd_pkg::MAX_LEN_RESET;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_hdr_cnt <= n_hdr_cnt;
                r_type    <= n_type;
                r_len     <= n_len;
                r_rem     <= n_rem;
                r_err     <= n_err;
            end
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == tsd_pkg::PH_DROP) |-> !cmd.has_val)
        else $error("value emitted while dropping");

    a_value_phase_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == tsd_pkg::PH_VALUE) |-> (r_rem != 32'd0))
        else $error("value phase with nothing remaining");

endmodule

// ----- rtl/tsd_fifo.sv -----
module tsd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  tsd_pkg::t_cmd i_wr_data,
    output logic          o_full,
    input  logic          i_rd_en,
    output tsd_pkg::t_cmd o_rd_data,
    output logic          o_not_empty
);

    tsd_pkg::t_cmd                   r_mem [tsd_pkg::CMD_DEPTH];
    logic [tsd_pkg::CMD_PTR_W-1:0]   r_wptr, r_rptr;
    logic [tsd_pkg::CMD_CNT_W-1:0]   r_count;
    logic                            wr, rd;

    assign o_full      = (r_count == tsd_pkg::CMD_CNT_W'(tsd_pkg::CMD_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_rd_data   = r_mem[r_rptr];
    assign wr          = i_wr_en & ~o_full;
    assign rd          = i_rd_en & o_not_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + tsd_pkg::CMD_PTR_W'(1);
            end
            if (rd) begin
                r_rptr <= r_rptr + tsd_pkg::CMD_PTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + tsd_pkg::CMD_CNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - tsd_pkg::CMD_CNT_W'(1);
            end
        end
    end

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr_en)
        else $error("command queue overrun");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && rd) |=> $stable(r_count))
        else $error("queue count moved on simultaneous push and pop");

endmodule

// ----- rtl/tsd_back.sv -----
module tsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_not_empty,
    input  tsd_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output tsd_pkg::t_out o_res
);

    tsd_pkg::t_cmd r_cur;
    logic          r_cur_valid;
    logic          r_val_sent;
    logic          show_val;
    logic          pop_ok;
    logic          release_cur;
    logic          load;

    assign show_val    = r_cur.has_val & ~r_val_sent;
    assign pop_ok      = i_pop & r_cur_valid;
    // a command with both parts stays for a second beat
    assign release_cur = pop_ok & (~show_val | ~r_cur.has_done);
    assign load        = i_q_not_empty & (~r_cur_valid | release_cur);
    assign o_q_pop     = load;
    assign o_empty     = ~r_cur_valid;

    always_comb begin
        o_res = '0;
        if (show_val) begin
            o_res.record_type = r_cur.record_type;
            o_res.value_byte  = r_cur.value_byte;
            o_res.value_empty = r_cur.value_empty;
            o_res.value_last  = r_cur.value_last;
        end else begin
            o_res.body_done    = 1'b1;
            o_res.parse_status = r_cur.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_val_sent  <= 1'b0;
        end else begin
            if (load) begin
                r_cur_valid <= 1'b1;
                r_val_sent  <= 1'b0;
            end else if (release_cur) begin
                r_cur_valid <= 1'b0;
                r_val_sent  <= 1'b0;
            end else if (pop_ok) begin
                r_val_sent  <= 1'b1;
            end
        end
    end

    a_done_follows_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && show_val && r_cur.has_done) |=> (r_cur_valid && !show_val))
        else $error("body-done beat lost after value beat");

    a_cmd_not_void: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_cur.has_val || r_cur.has_done))
        else $error("held command carries no result");

endmodule
